// ===== rtl/calendar_date_navigator_unit_defines.svh =====
// assertion macros for the calendar date navigator rtl, used by cdn_state
`ifndef CALENDAR_DATE_NAVIGATOR_UNIT_DEFINES_SVH
`define CALENDAR_DATE_NAVIGATOR_UNIT_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define CDN_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CDN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cdn_pkg.sv =====
// shared types, constants and calendar tables for the date navigator
package cdn_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int LEN_W    = 5;
    localparam int WDAY_W   = 3;
    localparam int CMD_W    = 3;
    localparam int MOD400_W = 9;

    localparam logic [YEAR_W-1:0]   YEAR_MIN     = 14'd1;
    localparam logic [YEAR_W-1:0]   YEAR_MAX     = 14'd9999;
    localparam logic [YEAR_W-1:0]   RESET_YEAR   = 14'd2026;
    localparam logic [MOD400_W-1:0] RESET_MOD400 = 9'd26;
    localparam logic [MOD400_W-1:0] MOD400_LAST  = 9'd399;
    localparam logic [MONTH_W-1:0]  MONTH_JAN    = 4'd0;
    localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_DEC    = 4'd11;
    localparam logic [DAY_W-1:0]    DAY_FIRST    = 5'd1;

    // reciprocal of 100 scaled by 2^19, also 1/400 when scaled by 2^21
    localparam logic [12:0] RECIP_100 = 13'd5243;
    // reciprocal of 7 scaled by 2^14
    localparam logic [11:0] RECIP_7   = 12'd2341;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD       = 3'd0,
        CMD_NEXT_DAY   = 3'd1,
        CMD_PREV_DAY   = 3'd2,
        CMD_NEXT_MONTH = 3'd3,
        CMD_PREV_MONTH = 3'd4,
        CMD_QUERY      = 3'd5
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } cmd_item_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [YEAR_W-1:0]   year;
        logic [MOD400_W-1:0] mod400;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } load_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [LEN_W-1:0]   len;
    } date_t;

    // leap test from the year modulo 400
    function automatic logic is_leap(input logic [MOD400_W-1:0] m400);
        is_leap = (m400[1:0] == 2'd0) && (m400 != 9'd100) && (m400 != 9'd200)
                  && (m400 != 9'd300);
    endfunction

    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        unique case (month)
            4'd1:                      month_len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    endfunction

    // 1 + floor(13*(mm+1)/5) with jan and feb counted as months 13 and 14
    function automatic logic [5:0] zeller_month_term(input logic [MONTH_W-1:0] month);
        unique case (month)
            4'd0:    zeller_month_term = 6'd37;
            4'd1:    zeller_month_term = 6'd40;
            4'd2:    zeller_month_term = 6'd11;
            4'd3:    zeller_month_term = 6'd14;
            4'd4:    zeller_month_term = 6'd16;
            4'd5:    zeller_month_term = 6'd19;
            4'd6:    zeller_month_term = 6'd21;
            4'd7:    zeller_month_term = 6'd24;
            4'd8:    zeller_month_term = 6'd27;
            4'd9:    zeller_month_term = 6'd29;
            4'd10:   zeller_month_term = 6'd32;
            default: zeller_month_term = 6'd34;
        endcase
    endfunction

endpackage

// ===== rtl/cdn_load_prep.sv =====
// input register and load-date clamping with year modulo 400
module cdn_load_prep (
    input  logic               clk,
    input  logic [2:0]         en,
    input  cdn_pkg::cmd_item_t in_item,
    output cdn_pkg::load_item_t load_item
);
    import cdn_pkg::*;

    cmd_item_t           raw_reg;
    cmd_item_t           clamp_reg;
    cmd_item_t           clamp_next;
    logic [4:0]          q400_reg;
    logic [26:0]         prod400;
    load_item_t          load_reg;
    load_item_t          load_next;
    logic [YEAR_W-1:0]   base400;
    logic [YEAR_W-1:0]   rem400;
    logic [LEN_W-1:0]    load_len;

    // clamp year and month, start year / 400
    always_comb
    begin
        clamp_next = raw_reg;
        if (raw_reg.year < YEAR_MIN)
        begin
            clamp_next.year = YEAR_MIN;
        end
        else if (raw_reg.year > YEAR_MAX)
        begin
            clamp_next.year = YEAR_MAX;
        end
        if (raw_reg.month > MONTH_DEC)
        begin
            clamp_next.month = MONTH_DEC;
        end
    end

    assign prod400 = 27'(clamp_next.year) * 27'(RECIP_100);

    // remainder, then clamp the day to the loaded month
    always_comb
    begin
        base400   = 14'(q400_reg) * 14'd400;
        rem400    = clamp_reg.year - base400;
        load_next = '{cmd: clamp_reg.cmd, year: clamp_reg.year,
                      mod400: rem400[MOD400_W-1:0], month: clamp_reg.month,
                      day: clamp_reg.day};
        load_len  = month_len(clamp_reg.month, is_leap(rem400[MOD400_W-1:0]));
        if (clamp_reg.day < DAY_FIRST)
        begin
            load_next.day = DAY_FIRST;
        end
        else if (clamp_reg.day > load_len)
        begin
            load_next.day = load_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            raw_reg <= in_item;
        end
        if (en[1])
        begin
            clamp_reg <= clamp_next;
            q400_reg  <= prod400[25:21];
        end
        if (en[2])
        begin
            load_reg <= load_next;
        end
    end

    assign load_item = load_reg;

endmodule

// ===== rtl/cdn_state.sv =====
// selected-date state and per-command update
`include "calendar_date_navigator_unit_defines.svh"

module cdn_state (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic                step_valid,
    input  cdn_pkg::load_item_t load_item,
    output cdn_pkg::date_t      date
);
    import cdn_pkg::*;

    logic [YEAR_W-1:0]   year_reg,   year_next;
    logic [MOD400_W-1:0] mod400_reg, mod400_next;
    logic [MONTH_W-1:0]  month_reg,  month_next;
    logic [DAY_W-1:0]    day_reg,    day_next;
    logic [LEN_W-1:0]    cur_len;
    logic [LEN_W-1:0]    len_next;
    date_t               date_reg;

    assign cur_len = month_len(month_reg, is_leap(mod400_reg));

    always_comb
    begin
        year_next   = year_reg;
        mod400_next = mod400_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        unique case (cmd_t'(load_item.cmd))
            CMD_LOAD:
            begin
                year_next   = load_item.year;
                mod400_next = load_item.mod400;
                month_next  = load_item.month;
                day_next    = load_item.day;
            end
            CMD_NEXT_DAY:
            begin
                day_next = (day_reg >= cur_len) ? DAY_FIRST : day_reg + 5'd1;
            end
            CMD_PREV_DAY:
            begin
                day_next = (day_reg <= DAY_FIRST || day_reg > cur_len) ? cur_len
                                                                       : day_reg - 5'd1;
            end
            CMD_NEXT_MONTH:
            begin
                if (month_reg >= MONTH_DEC)
                begin
                    if (year_reg < YEAR_MAX)
                    begin
                        month_next  = MONTH_JAN;
                        year_next   = year_reg + 14'd1;
                        mod400_next = (mod400_reg == MOD400_LAST) ? 9'd0
                                                                  : mod400_reg + 9'd1;
                    end
                end
                else
                begin
                    month_next = month_reg + 4'd1;
                end
            end
            CMD_PREV_MONTH:
            begin
                if (month_reg == MONTH_JAN)
                begin
                    if (year_reg > YEAR_MIN)
                    begin
                        month_next  = MONTH_DEC;
                        year_next   = year_reg - 14'd1;
                        mod400_next = (mod400_reg == 9'd0) ? MOD400_LAST
                                                           : mod400_reg - 9'd1;
                    end
                end
                else
                begin
                    month_next = month_reg - 4'd1;
                end
            end
            default:
            begin
            end
        endcase
        len_next = month_len(month_next, is_leap(mod400_next));
        // month steps can land on a shorter month
        if (day_next > len_next)
        begin
            day_next = len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg   <= RESET_YEAR;
            mod400_reg <= RESET_MOD400;
            month_reg  <= MONTH_JAN;
            day_reg    <= DAY_FIRST;
        end
        else if (step_en && step_valid)
        begin
            year_reg   <= year_next;
            mod400_reg <= mod400_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            date_reg <= '{year: year_next, month: month_next, day: day_next,
                          len: len_next};
        end
    end

    assign date = date_reg;

    `CDN_ASSERT_ALWAYS(a_day_in_month, day_reg >= DAY_FIRST && day_reg <= cur_len, "day out of month")
    `CDN_ASSERT_ALWAYS(a_date_bounds, month_reg <= MONTH_DEC && year_reg >= YEAR_MIN && year_reg <= YEAR_MAX && mod400_reg <= MOD400_LAST, "date out of bounds")
    `CDN_ASSERT_NEXT(a_hold_idle, !(step_en && step_valid), $stable(year_reg) && $stable(mod400_reg) && $stable(month_reg) && $stable(day_reg), "state moved without a command")
    `CDN_ASSERT_NEXT(a_result_matches, step_en && step_valid, date_reg.year == year_reg && date_reg.month == month_reg && date_reg.day == day_reg, "result differs from state")

endmodule

// ===== rtl/cdn_weekday.sv =====
// weekday of the first of the month, three register stages
module cdn_weekday (
    input  logic                     clk,
    input  logic [2:0]               en,
    input  cdn_pkg::date_t           date_in,
    output cdn_pkg::date_t           date_out,
    output logic [cdn_pkg::WDAY_W-1:0] weekday
);
    import cdn_pkg::*;

    logic [YEAR_W-1:0] yy;
    logic [26:0]       prod100;
    date_t             s1_date_reg;
    logic [YEAR_W-1:0] yy_reg;
    logic [6:0]        j_reg;

    logic [YEAR_W-1:0] k_full;
    logic [6:0]        k;
    logic [9:0]        sum;
    date_t             s2_date_reg;
    logic [9:0]        sum_reg;

    logic [21:0]       q_prod;
    logic [9:0]        h_full;
    logic [2:0]        h;
    logic [WDAY_W-1:0] wd;
    date_t             out_date_reg;
    logic [WDAY_W-1:0] wd_reg;

    // jan and feb belong to the previous year
    assign yy      = (date_in.month <= MONTH_FEB) ? date_in.year - 14'd1 : date_in.year;
    assign prod100 = 27'(yy) * 27'(RECIP_100);

    always_comb
    begin
        k_full = yy_reg - 14'(j_reg) * 14'd100;
        k      = k_full[6:0];
        sum    = 10'(zeller_month_term(s1_date_reg.month)) + 10'(k) + 10'(k[6:2])
                 + 10'(j_reg[6:2]) + 10'(j_reg) * 10'd5;
    end

    // sum mod 7, then shift so that monday is zero
    always_comb
    begin
        q_prod = 22'(sum_reg) * 22'(RECIP_7);
        h_full = sum_reg - 10'(q_prod[20:14]) * 10'd7;
        h      = h_full[2:0];
        wd     = (h >= 3'd2) ? h - 3'd2 : h + 3'd5;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_date_reg <= date_in;
            yy_reg      <= yy;
            j_reg       <= prod100[25:19];
        end
        if (en[1])
        begin
            s2_date_reg <= s1_date_reg;
            sum_reg     <= sum;
        end
        if (en[2])
        begin
            out_date_reg <= s2_date_reg;
            wd_reg       <= wd;
        end
    end

    assign date_out = out_date_reg;
    assign weekday  = wd_reg;

endmodule

// ===== rtl/calendar_date_navigator_unit.sv =====
// top level of the calendar date navigator: stream ports and pipeline flow control
//
// Holds a selected proleptic Gregorian date (reset: January 1st, 2026) and moves it
// by command: load a date (year clamped to 1..9999, month to 0..11, day to the month),
// step the day forward or back wrapping inside the month, step the month forward or
// back carrying into the year (saturating at January of year 1 and December of 9999,
// day clamped to the new month), or query; unused command codes act as a query.
// Every command transaction gives exactly one result transaction with the date, the
// month length with leap years, and the weekday of the 1st (0 = Monday). The block
// takes one command transaction per clock cycle while the output side does not stall.
// The seven stages are: input register, load clamping with a reciprocal multiply,
// year modulo 400, the date state update, a reciprocal multiply for the century,
// the weekday sum, and the output register with the reduction modulo 7. The state
// update is the only loop and closes within its one stage, so back-to-back commands
// always see the date left by the one before. Each stage holds its item while the
// next is full and stalled, so empty stages keep filling while a finished result
// waits to be taken.
module calendar_date_navigator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // load_year[13:0], load_month[17:14], load_day[22:18]
    input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // year_out[13:0], month_out[17:14], day_out[22:18],
                                        // month_length[27:23], first_weekday[30:28]
);
    import cdn_pkg::*;

    localparam int NUM_STAGES = 7;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   adv;       // stage may load this cycle
    cmd_item_t             in_item;
    load_item_t            load_item;
    date_t                 state_date;
    date_t                 out_date;
    logic [WDAY_W-1:0]     out_weekday;

    // a stage advances when it is empty or its successor advances
    always_comb
    begin
        adv[NUM_STAGES] = m_axis_tready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_axis_tready = adv[0];

    // unpack the command transaction
    assign in_item = '{cmd: s_axis_tuser, year: s_axis_tdata[13:0],
                       month: s_axis_tdata[17:14], day: s_axis_tdata[22:18]};

    cdn_load_prep u_load_prep (
        .clk       (clk),
        .en        (adv[2:0]),
        .in_item   (in_item),
        .load_item (load_item)
    );

    // state moves only when a valid command enters the state stage
    cdn_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (adv[3]),
        .step_valid (valid_reg[2]),
        .load_item  (load_item),
        .date       (state_date)
    );

    cdn_weekday u_weekday (
        .clk      (clk),
        .en       (adv[6:4]),
        .date_in  (state_date),
        .date_out (out_date),
        .weekday  (out_weekday)
    );

    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {1'b0, out_weekday, out_date.len, out_date.day,
                            out_date.month, out_date.year};

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the calendar date navigator unit
`timescale 1ns / 1ps

module testbench;
    import cdn_pkg::*;

    // command codes outside the package enum, both must behave as a query
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int DIRECTED_COUNT   = 25;
    localparam int RANDOM_PER_PHASE = 350;
    localparam int DRAIN_CYCLES     = 20;      // pipeline is seven stages deep
    localparam int CYCLE_LIMIT      = 200000;

    // result transaction as it sits in m_axis_tdata, lowest field in the lowest bits
    typedef struct packed {
        logic [WDAY_W-1:0]  wday;
        logic [LEN_W-1:0]   len;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_result_t;

    // one directed command; fixed rows carry a hand-written expected result
    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mo;
        logic [DAY_W-1:0]   dy;
        logic               fixed;
        date_result_t       want;
    } stim_row_t;

    localparam date_result_t FREE = '0;

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // state straight after reset, then the spare codes acting as a query
        '{CMD_QUERY,      14'd0,     4'd0,  5'd0,  1'b1, '{3'd3, 5'd31, 5'd1,  4'd0,  14'd2026}},
        '{CMD_SPARE_A,    14'd0,     4'd0,  5'd0,  1'b1, '{3'd3, 5'd31, 5'd1,  4'd0,  14'd2026}},
        '{CMD_SPARE_B,    14'd0,     4'd0,  5'd0,  1'b1, '{3'd3, 5'd31, 5'd1,  4'd0,  14'd2026}},
        // day wrap in both directions
        '{CMD_PREV_DAY,   14'd0,     4'd0,  5'd0,  1'b1, '{3'd3, 5'd31, 5'd31, 4'd0,  14'd2026}},
        '{CMD_NEXT_DAY,   14'd0,     4'd0,  5'd0,  1'b1, '{3'd3, 5'd31, 5'd1,  4'd0,  14'd2026}},
        // month step with year borrow and carry
        '{CMD_PREV_MONTH, 14'd0,     4'd0,  5'd0,  1'b0, FREE},
        '{CMD_NEXT_MONTH, 14'd0,     4'd0,  5'd0,  1'b0, FREE},
        // load clamping: year 0 and day 0 at the low end, month 15 at the high end
        '{CMD_LOAD,       14'd0,     4'd15, 5'd0,  1'b1, '{3'd5, 5'd31, 5'd1,  4'd11, 14'd1}},
        '{CMD_LOAD,       14'd1,     4'd0,  5'd0,  1'b1, '{3'd0, 5'd31, 5'd1,  4'd0,  14'd1}},
        // previous month saturates at january of year 1
        '{CMD_PREV_MONTH, 14'd0,     4'd0,  5'd0,  1'b1, '{3'd0, 5'd31, 5'd1,  4'd0,  14'd1}},
        '{CMD_PREV_DAY,   14'd0,     4'd0,  5'd0,  1'b1, '{3'd0, 5'd31, 5'd31, 4'd0,  14'd1}},
        // all-ones load clamps to december 9999, next month saturates there
        '{CMD_LOAD,       14'd16383, 4'd15, 5'd31, 1'b1, '{3'd2, 5'd31, 5'd31, 4'd11, 14'd9999}},
        '{CMD_NEXT_MONTH, 14'd0,     4'd0,  5'd0,  1'b1, '{3'd2, 5'd31, 5'd31, 4'd11, 14'd9999}},
        '{CMD_NEXT_DAY,   14'd0,     4'd0,  5'd0,  1'b1, '{3'd2, 5'd31, 5'd1,  4'd11, 14'd9999}},
        '{CMD_LOAD,       14'd10000, 4'd12, 5'd5,  1'b1, '{3'd2, 5'd31, 5'd5,  4'd11, 14'd9999}},
        // leap february: day beyond month length clamps
        '{CMD_LOAD,       14'd2000,  4'd1,  5'd31, 1'b1, '{3'd1, 5'd29, 5'd29, 4'd1,  14'd2000}},
        '{CMD_NEXT_DAY,   14'd0,     4'd0,  5'd0,  1'b0, FREE},
        // century years that are not leap
        '{CMD_LOAD,       14'd1900,  4'd1,  5'd29, 1'b0, FREE},
        '{CMD_PREV_DAY,   14'd0,     4'd0,  5'd0,  1'b0, FREE},
        // month step clamps the day to the new month
        '{CMD_LOAD,       14'd2024,  4'd0,  5'd31, 1'b0, FREE},
        '{CMD_NEXT_MONTH, 14'd0,     4'd0,  5'd0,  1'b0, FREE},
        '{CMD_LOAD,       14'd2023,  4'd2,  5'd31, 1'b0, FREE},
        '{CMD_PREV_MONTH, 14'd0,     4'd0,  5'd0,  1'b0, FREE},
        // alternating bit patterns on every load field
        '{CMD_LOAD,       14'h2AAA,  4'd10, 5'd21, 1'b0, FREE},
        '{CMD_LOAD,       14'h1555,  4'd5,  5'd10, 1'b0, FREE}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // load_year[13:0], load_month[17:14], load_day[22:18]
    logic [2:0]  s_axis_tuser = '0;    // cmd[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // year, month, day, month_length, first_weekday

    // selected date as the predictor sees it
    logic [YEAR_W-1:0]  cal_year;
    logic [MONTH_W-1:0] cal_month;
    logic [DAY_W-1:0]   cal_day;

    date_result_t expected_dates [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_errors       = 0;
    int n_checked      = 0;
    int n_loads        = 0;
    int n_day_steps    = 0;
    int n_month_steps  = 0;
    int n_queries      = 0;
    int cycle_count    = 0;

    calendar_date_navigator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // calendar arithmetic for the predictor
    // ---------------------------------------------------------------

    function automatic logic [LEN_W-1:0] pred_month_len(input logic [YEAR_W-1:0] y,
                                                        input logic [MONTH_W-1:0] m);
        int unsigned yi;
        bit          leap;
        yi   = y;
        leap = ((yi % 4) == 0 && (yi % 100) != 0) || (yi % 400) == 0;
        case (m)
            MONTH_FEB:               return leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: return 5'd30;
            default:                 return 5'd31;
        endcase
    endfunction

    // zeller's congruence, h = 0 is saturday, shifted so monday is 0
    function automatic logic [WDAY_W-1:0] weekday_of_first(input logic [YEAR_W-1:0] y,
                                                           input logic [MONTH_W-1:0] m);
        int unsigned zm, zy, k, j, h;
        zm = m;
        zm = zm + 1;
        zy = y;
        // january and february count as months 13 and 14 of the year before
        if (zm < 3)
        begin
            zm = zm + 12;
            zy = (zy > 0) ? zy - 1 : 0;
        end
        k = zy % 100;
        j = zy / 100;
        h = (1 + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        return WDAY_W'((h + 5) % 7);
    endfunction

    function automatic void clamp_cal_day();
        logic [LEN_W-1:0] len;
        len = pred_month_len(cal_year, cal_month);
        if (cal_day > len)
            cal_day = len;
        if (cal_day < DAY_FIRST)
            cal_day = DAY_FIRST;
    endfunction

    // apply one command to the predicted date and return the result it reports
    function automatic date_result_t advance_date(input logic [CMD_W-1:0]   op,
                                                  input logic [YEAR_W-1:0]  ly,
                                                  input logic [MONTH_W-1:0] lm,
                                                  input logic [DAY_W-1:0]   ld);
        date_result_t     r;
        logic [LEN_W-1:0] len;
        len = pred_month_len(cal_year, cal_month);
        case (op)
            CMD_LOAD:
            begin
                cal_year  = (ly < YEAR_MIN) ? YEAR_MIN : ((ly > YEAR_MAX) ? YEAR_MAX : ly);
                cal_month = (lm > MONTH_DEC) ? MONTH_DEC : lm;
                cal_day   = ld;
                clamp_cal_day();
            end
            CMD_NEXT_DAY:
                cal_day = (cal_day >= len) ? DAY_FIRST : cal_day + 5'd1;
            CMD_PREV_DAY:
                cal_day = (cal_day <= DAY_FIRST || cal_day > len) ? len : cal_day - 5'd1;
            CMD_NEXT_MONTH:
            begin
                if (cal_month >= MONTH_DEC)
                begin
                    // december 9999 stays put
                    if (cal_year < YEAR_MAX)
                    begin
                        cal_month = MONTH_JAN;
                        cal_year  = cal_year + 14'd1;
                    end
                end
                else
                    cal_month = cal_month + 4'd1;
                clamp_cal_day();
            end
            CMD_PREV_MONTH:
            begin
                if (cal_month == MONTH_JAN)
                begin
                    // january of year 1 stays put
                    if (cal_year > YEAR_MIN)
                    begin
                        cal_month = MONTH_DEC;
                        cal_year  = cal_year - 14'd1;
                    end
                end
                else
                    cal_month = cal_month - 4'd1;
                clamp_cal_day();
            end
            default:
                ;   // query and spare codes leave the date alone
        endcase
        r.year  = cal_year;
        r.month = cal_month;
        r.day   = cal_day;
        r.len   = pred_month_len(cal_year, cal_month);
        r.wday  = weekday_of_first(cal_year, cal_month);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // command side: optional idle gap, then hold tvalid until accepted
    // ---------------------------------------------------------------

    task automatic issue_command(input logic [CMD_W-1:0]   op,
                                 input logic [YEAR_W-1:0]  ly,
                                 input logic [MONTH_W-1:0] lm,
                                 input logic [DAY_W-1:0]   ld,
                                 input logic               fixed,
                                 input date_result_t       want);
        date_result_t calc;
        bit           taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, ld, lm, ly};
        // tready is settled by the falling edge and holds until the next rising edge
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        calc = advance_date(op, ly, lm, ld);
        expected_dates.push_back(fixed ? want : calc);
        case (op)
            CMD_LOAD:                       n_loads++;
            CMD_NEXT_DAY, CMD_PREV_DAY:     n_day_steps++;
            CMD_NEXT_MONTH, CMD_PREV_MONTH: n_month_steps++;
            default:                        n_queries++;
        endcase
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls and the scoreboard check
    // ---------------------------------------------------------------

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // a result transaction completes at the next rising edge when both are high here
    always @(negedge clk)
    begin
        date_result_t got;
        date_result_t want;
        bit           bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = date_result_t'(m_axis_tdata[30:0]);
            if (expected_dates.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result transaction: %0d-%0d-%0d len %0d wday %0d",
                             got.year, got.month, got.day, got.len, got.wday);
            end
            else
            begin
                want = expected_dates.pop_front();
                n_checked++;
                bad = (got.year !== want.year) || (got.month !== want.month)
                      || (got.day !== want.day) || (got.len !== want.len)
                      || (got.wday !== want.wday);
                if (bad)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("result %0d mismatch: expected %0d-%0d-%0d len %0d wday %0d",
                                 n_checked, want.year, want.month, want.day, want.len,
                                 want.wday);
                        $display("    got %0d-%0d-%0d len %0d wday %0d",
                                 got.year, got.month, got.day, got.len, got.wday);
                    end
                end
            end
        end
    end

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_dates.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        logic [CMD_W-1:0]   op;
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mo;
        logic [DAY_W-1:0]   dy;
        int                 pick;

        cal_year  = RESET_YEAR;
        cal_month = MONTH_JAN;
        cal_day   = DAY_FIRST;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling on either side
        for (int i = 0; i < DIRECTED_COUNT; i++)
            issue_command(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].yr, DIRECTED_ROWS[i].mo,
                          DIRECTED_ROWS[i].dy, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

        // random commands under four pacing phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
            endcase
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    op = CMD_LOAD;
                else if (pick < 35)
                    op = CMD_NEXT_DAY;
                else if (pick < 50)
                    op = CMD_PREV_DAY;
                else if (pick < 65)
                    op = CMD_NEXT_MONTH;
                else if (pick < 80)
                    op = CMD_PREV_MONTH;
                else if (pick < 92)
                    op = CMD_QUERY;
                else
                    op = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;

                // year mix: any 14-bit value, near the saturation ends, or in range
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    yr = YEAR_W'($urandom);
                else if (pick == 1)
                    yr = ($urandom_range(0, 1) != 0) ? YEAR_W'($urandom_range(0, 3))
                                                     : YEAR_W'($urandom_range(9996, 9999));
                else
                    yr = YEAR_W'($urandom_range(1, 9999));
                mo = MONTH_W'($urandom_range(0, 15));
                dy = DAY_W'($urandom_range(0, 31));
                // load fields ride along on every command and must be ignored by the others
                issue_command(op, yr, mo, dy, 1'b0, FREE);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands: %0d loads, %0d day steps, %0d month steps, %0d queries",
                 n_loads + n_day_steps + n_month_steps + n_queries, n_loads, n_day_steps,
                 n_month_steps, n_queries);
        $display("checked %0d results across four pacing phases, %0d mismatches",
                 n_checked, n_errors);
        if (n_errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
